// ===== sv/hsr_pkg.sv =====
// ----------------------------------------------------------------------------
// hsr_pkg
// Shared types, constants and helpers of the hexagonal RGB rescaler.
// ----------------------------------------------------------------------------
package hsr_pkg;

	localparam int MAX_EXPONENT = 2;
	localparam int SEPT_BASE    = 7;

	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 3;
	localparam int PIX_W    = CHAN_W * NUM_CHAN;
	localparam int EXP_W    = 2;
	localparam int POS_W    = 6;
	localparam int SUM_W    = 14;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 2;

	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int SIZE_ONE    = 1;
	localparam int SIZE_SEVEN  = SEPT_BASE;
	localparam int SIZE_MAX    = SEPT_BASE * SEPT_BASE;
	localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
	localparam int RECIP_SEVEN = ((1 << RECIP_SHIFT) + SIZE_SEVEN - 1) / SIZE_SEVEN;
	localparam int RECIP_MAX   = ((1 << RECIP_SHIFT) + SIZE_MAX - 1) / SIZE_MAX;

	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT  = 1'b1;

	localparam logic DIR_DOWN = 1'b0;
	localparam logic DIR_UP   = 1'b1;

	typedef struct packed {
		logic accumulate;
		logic finish;
		logic pass;
		logic clear;
		logic advance;
	} lane_ctl_t;

	function automatic logic [EXP_W-1:0] clamp_exp(input logic [EXP_W-1:0] e);
		logic [EXP_W-1:0] r;
		r = e;
		if (int'(e) > MAX_EXPONENT) begin
			r = EXP_W'(MAX_EXPONENT);
		end
		return r;
	endfunction

	function automatic logic [POS_W-1:0] group_size(input logic [EXP_W-1:0] e);
		logic [POS_W-1:0] r;
		r = POS_W'(SIZE_ONE);
		case (clamp_exp(e))
			2'd0:    r = POS_W'(SIZE_ONE);
			2'd1:    r = POS_W'(SIZE_SEVEN);
			default: r = POS_W'(SIZE_MAX);
		endcase
		return r;
	endfunction

	function automatic logic [RECIP_W-1:0] group_recip(input logic [EXP_W-1:0] e);
		logic [RECIP_W-1:0] r;
		r = RECIP_W'(RECIP_ONE);
		case (clamp_exp(e))
			2'd0:    r = RECIP_W'(RECIP_ONE);
			2'd1:    r = RECIP_W'(RECIP_SEVEN);
			default: r = RECIP_W'(RECIP_MAX);
		endcase
		return r;
	endfunction

endpackage

// ===== sv/hsr_lane.sv =====
// ----------------------------------------------------------------------------
// hsr_lane
// One color channel: group accumulator, finished-sum stage and a
// reciprocal-multiply stage that yields the truncated average.
// ----------------------------------------------------------------------------
module hsr_lane (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hsr_pkg::lane_ctl_t      ctl,
	input  logic [hsr_pkg::CHAN_W-1:0]  chan,
	input  logic [hsr_pkg::RECIP_W-1:0] recip,
	output logic [hsr_pkg::CHAN_W-1:0]  avg_s2
);
	import hsr_pkg::*;

	localparam int PROD_W = SUM_W + RECIP_W;

	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sum_next;
	logic [SUM_W-1:0]  val_s1;
	logic [PROD_W-1:0] prod;

	assign sum_next = sum_q + SUM_W'(chan);
	assign prod     = PROD_W'(val_s1) * PROD_W'(recip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.clear || ctl.finish) begin
			sum_q <= '0;
		end else if (ctl.accumulate) begin
			sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			val_s1 <= sum_next;
		end else if (ctl.pass) begin
			val_s1 <= SUM_W'(chan);
		end
		if (ctl.advance) begin
			avg_s2 <= prod[RECIP_SHIFT +: CHAN_W];
		end
	end

endmodule

// ===== sv/hsr_merge.sv =====
// ----------------------------------------------------------------------------
// hsr_merge
// Output register: combines the lane averages into one pixel and sends it
// the requested number of times, marking the last copy.
// ----------------------------------------------------------------------------
module hsr_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [hsr_pkg::PIX_W-1:0]  in_pixel,
	input  logic [hsr_pkg::POS_W-1:0]  in_copies,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [hsr_pkg::PIX_W-1:0]  m_tdata,
	output logic                       m_tlast
);
	import hsr_pkg::*;

	logic [POS_W-1:0] left_q;
	logic             valid_q;
	logic [PIX_W-1:0] pixel_q;

	assign m_tvalid = valid_q;
	assign m_tdata  = pixel_q;
	assign m_tlast  = (left_q == '0);
	assign in_ready = !valid_q || (m_tready && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			left_q  <= '0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
			left_q  <= in_copies - POS_W'(1);
		end else if (valid_q && m_tready) begin
			if (m_tlast) begin
				valid_q <= 1'b0;
			end else begin
				left_q <= left_q - POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pixel_q <= in_pixel;
		end
	end

endmodule

// ===== sv/hex_septree_rgb_rescaler_core.sv =====
// ----------------------------------------------------------------------------
// hex_septree_rgb_rescaler_core
// Box-average decimation and replication upsampling of RGB pixels that
// arrive in septree order, by a group size of 1, 7 or 49.
// ----------------------------------------------------------------------------
// Pixels enter on the s_t* channel, one pixel per beat, red in the low byte.
// Results leave on the m_t* channel in the same layout, with m_tlast set on
// the final copy of a replicated pixel and on every averaged pixel.
// The cfg channel writes direction (index 0) and factor_exponent (index 1);
// any write drops a partial group. cfg_ready is always high.
// In down mode one pixel can be taken every cycle unless the receiver stalls,
// and an average appears one beat per group. In up mode each pixel yields G
// output beats, one per cycle while m_tready is high, and the next pixel is
// taken while copies go out. The accepting edge loads the lane stage; the
// reciprocal multiply and the output register are then loaded in turn, and
// the first result beat of a pixel or group is valid from the output register.
// Three channel lanes work in parallel and the output register merges them.
// When the receiver stalls, the output register holds its beat and the two
// stages behind it fill before s_tready drops.
// Reset clears the group sums and the pipeline, selects down mode and sets
// the exponent to one.
// ----------------------------------------------------------------------------
module hex_septree_rgb_rescaler_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hsr_pkg::PIX_W-1:0]         s_tdata,  // red_in, green_in, blue_in
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hsr_pkg::PIX_W-1:0]         m_tdata,  // red_out, green_out, blue_out
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hsr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hsr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import hsr_pkg::*;

	logic                dir_q;
	logic [EXP_W-1:0]    exp_q;
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    size;
	logic [POS_W:0]      pos_inc;
	logic                group_end;
	logic                cfg_wr;
	logic                accept;
	logic                load_s1;
	logic                valid_s1;
	logic                valid_s2;
	logic [POS_W-1:0]    copies_s1;
	logic [POS_W-1:0]    copies_s2;
	logic [RECIP_W-1:0]  recip_s1;
	logic                adv_s2;
	logic                adv_s3;
	logic                s1_free;
	logic                s2_free;
	logic                merge_ready;
	lane_ctl_t           ctl;
	logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_in;
	logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_avg;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign size      = group_size(exp_q);
	assign pos_inc   = {1'b0, pos_q} + (POS_W+1)'(1);
	assign group_end = (pos_inc >= {1'b0, size});

	assign adv_s3   = valid_s2 && merge_ready;
	assign s2_free  = !valid_s2 || adv_s3;
	assign adv_s2   = valid_s1 && s2_free;
	assign s1_free  = !valid_s1 || adv_s2;
	assign s_tready = s1_free;
	assign accept   = s_tvalid && s_tready;

	assign ctl.accumulate = accept && (dir_q == DIR_DOWN);
	assign ctl.finish     = accept && (dir_q == DIR_DOWN) && group_end;
	assign ctl.pass       = accept && (dir_q == DIR_UP);
	assign ctl.clear      = cfg_wr;
	assign ctl.advance    = adv_s2;
	assign load_s1        = ctl.finish || ctl.pass;

	assign chan_in = s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= DIR_DOWN;
			exp_q    <= EXP_W'(1);
			pos_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_DIRECTION: dir_q <= cfg_data[0];
					REG_EXPONENT:  exp_q <= cfg_data;
					default:       ;
				endcase
				pos_q <= '0;
			end else if (ctl.accumulate) begin
				pos_q <= group_end ? '0 : pos_inc[POS_W-1:0];
			end
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (adv_s3) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			copies_s1 <= ctl.pass ? size : POS_W'(SIZE_ONE);
			recip_s1  <= ctl.pass ? RECIP_W'(RECIP_ONE) : group_recip(exp_q);
		end
		if (adv_s2) begin
			copies_s2 <= copies_s1;
		end
	end

	for (genvar i = 0; i < NUM_CHAN; i++) begin : g_lane
		hsr_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.chan   (chan_in[i]),
			.recip  (recip_s1),
			.avg_s2 (chan_avg[i])
		);
	end

	hsr_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_ready  (merge_ready),
		.in_pixel  (chan_avg),
		.in_copies (copies_s2),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	a_pos_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < size)
		else $error("group position reached the group size");

	a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |-> (!valid_s1 || adv_s2))
		else $error("finished sum loaded over a pending one");

	a_copies_continue: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |=> m_tvalid)
		else $error("replicated pixel ended before its last copy");

endmodule
